@@ design/asht_pkg.sv @@
// types, codes and helpers shared by the access site hit table
package asht_pkg;

  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned COUNT_W     = 64;
  localparam int unsigned TID_W       = 32;
  localparam int unsigned SLOT_W      = 7;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned MAX_THREADS = 6;

  localparam logic [REQ_W-1:0] REQ_HIT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_EXISTING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLAIMED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef logic [MAX_THREADS-1:0][TID_W-1:0] thread_list_t;

  typedef struct packed {
    logic              cmp_en;
    logic              upd_en;
    logic              hit_op;
    logic              read_op;
    logic              clear_op;
    logic              claim_en;
    logic [ADDR_W-1:0] address;
    logic [TID_W-1:0]  tid;
    logic [IDX_W-1:0]  index;
  } cell_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  index;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    thread_list_t       threads;
  } cell_view_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_W'(1);
  endfunction

endpackage

@@ design/asht_cell.sv @@
// one table entry: address, count and thread list with its own compare
module asht_cell #(
  parameter int unsigned THREADS_PER_ENTRY = 6,
  parameter int unsigned CELL_ID           = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  asht_pkg::cell_cmd_t  cmd,
  input  logic                 prev_used,
  output logic                 used,
  output logic                 match_hit,
  output logic                 free_hit,
  output asht_pkg::cell_view_t view
);
  import asht_pkg::*;

  localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_ID);

  logic [ADDR_W-1:0]                        address;
  logic [COUNT_W-1:0]                       count;
  logic [THREADS_PER_ENTRY-1:0][TID_W-1:0]  slots;
  logic                                     match_q;
  logic                                     free_q;
  logic                                     idx_q;
  logic                                     sel;
  logic                                     tid_seen;
  logic [THREADS_PER_ENTRY-1:0]             slot_take;

  assign match_hit = match_q;
  assign free_hit  = free_q;

  always_comb begin
    sel = (cmd.hit_op & match_q) | (cmd.hit_op & cmd.claim_en & free_q) |
          (cmd.read_op & idx_q);
  end

  // first empty slot takes a new nonzero thread id
  always_comb begin
    logic prior_nz;
    prior_nz = 1'b1;
    tid_seen = 1'b0;
    for (int k = 0; k < THREADS_PER_ENTRY; k++) begin
      if (slots[k] == cmd.tid) begin
        tid_seen = 1'b1;
      end
    end
    for (int k = 0; k < THREADS_PER_ENTRY; k++) begin
      slot_take[k] = !tid_seen && (cmd.tid != '0) && (slots[k] == '0) && prior_nz;
      prior_nz = (slots[k] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      if (cmd.cmp_en) begin
        match_q <= used && (address == cmd.address);
        free_q  <= !used && prev_used && (cmd.address != '0);
        idx_q   <= (cmd.index == MY_ID);
      end
      if (cmd.upd_en) begin
        if (cmd.clear_op) begin
          used <= 1'b0;
        end else if (cmd.hit_op && sel && !match_q) begin
          used <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en && cmd.hit_op && sel) begin
      if (match_q) begin
        count <= sat_inc(count);
        for (int k = 0; k < THREADS_PER_ENTRY; k++) begin
          if (slot_take[k]) begin
            slots[k] <= cmd.tid;
          end
        end
      end else begin
        address <= cmd.address;
        count   <= COUNT_W'(1);
        for (int k = 0; k < THREADS_PER_ENTRY; k++) begin
          slots[k] <= (k == 0) ? cmd.tid : '0;
        end
      end
    end
  end

  always_comb begin
    view = '0;
    if (sel && used) begin
      view.index   = MY_ID[SLOT_W-1:0];
      view.address = address;
      view.count   = count;
      for (int k = 0; k < THREADS_PER_ENTRY; k++) begin
        view.threads[k] = slots[k];
      end
    end
  end

endmodule

@@ design/access_site_hit_table.sv @@
// access site hit table: request sequencer, hit counters and a row of entry cells
//
// Input channel: req_type, hit_address, thread_id and entry_index move in one
// transfer when in_valid is high and in_stall is low. A hit request counts the
// site in its entry, claims the next free entry, or counts an overflow; a read
// request returns one entry; a clear request empties the table and counters.
// Output channel: one result per request, moved when out_valid is high and
// out_stall is low. Each result holds the entry touched and both totals.
// Steps after the input transfer: compare in all cells, update of the chosen cell,
// readout merge into the output register. The block takes one request at a time;
// it takes no new request until the compare, update and readout steps through the
// cell row are done.
// A stalled result holds its register; the next request may already be taken
// and waits at readout until the output register is free.
// Reset empties the table, zeroes both totals and drops any pending result.
module access_site_hit_table #(
  parameter int unsigned ENTRIES           = 96,
  parameter int unsigned THREADS_PER_ENTRY = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [asht_pkg::REQ_W-1:0]      req_type,
  input  logic [asht_pkg::ADDR_W-1:0]     hit_address,
  input  logic [asht_pkg::TID_W-1:0]      thread_id,
  input  logic [asht_pkg::SLOT_W-1:0]     entry_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [asht_pkg::STATUS_W-1:0]   status,
  output logic [asht_pkg::SLOT_W-1:0]     slot_index,
  output logic [asht_pkg::ADDR_W-1:0]     site_address,
  output logic [asht_pkg::COUNT_W-1:0]    site_count,
  output logic [asht_pkg::TID_W-1:0]      first_thread,
  output logic [asht_pkg::TID_W-1:0]      second_thread,
  output logic [asht_pkg::TID_W-1:0]      third_thread,
  output logic [asht_pkg::TID_W-1:0]      fourth_thread,
  output logic [asht_pkg::TID_W-1:0]      fifth_thread,
  output logic [asht_pkg::TID_W-1:0]      sixth_thread,
  output logic [asht_pkg::COUNT_W-1:0]    total_hits,
  output logic [asht_pkg::COUNT_W-1:0]    overflow_hits
);
  import asht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_UPD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [REQ_W-1:0]    req_kind;
  logic [ADDR_W-1:0]   req_address;
  logic [TID_W-1:0]    req_tid;
  logic [SLOT_W-1:0]   req_entry;
  logic [COUNT_W-1:0]  hit_total;
  logic [COUNT_W-1:0]  overflow_total;

  logic                is_hit;
  logic                is_clear;
  logic                is_read;
  logic                any_match;
  logic                any_free;
  logic                out_free;
  cell_cmd_t           cmd;
  cell_view_t          merged;

  logic [ENTRIES-1:0]  used_vec;
  logic [ENTRIES-1:0]  match_vec;
  logic [ENTRIES-1:0]  free_vec;
  cell_view_t          views [ENTRIES];

  assign is_hit    = (req_kind == REQ_HIT);
  assign is_clear  = (req_kind == REQ_CLEAR);
  assign is_read   = !is_hit && !is_clear;
  assign any_match = |match_vec;
  assign any_free  = |free_vec;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.cmp_en   = (state == S_CMP);
    cmd.upd_en   = (state == S_UPD);
    cmd.hit_op   = is_hit;
    cmd.read_op  = is_read;
    cmd.clear_op = is_clear;
    cmd.claim_en = !any_match;
    cmd.address  = req_address;
    cmd.tid      = req_tid;
    cmd.index    = {1'b0, req_entry};
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic prev_used;
    if (i == 0) begin : g_head
      assign prev_used = 1'b1;
    end else begin : g_link
      assign prev_used = used_vec[i-1];
    end
    asht_cell #(
      .THREADS_PER_ENTRY(THREADS_PER_ENTRY),
      .CELL_ID(i)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .cmd(cmd),
      .prev_used(prev_used),
      .used(used_vec[i]),
      .match_hit(match_vec[i]),
      .free_hit(free_vec[i]),
      .view(views[i])
    );
  end

  // at most one cell is selected, so an or of all views picks it
  always_comb begin
    merged = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      merged = cell_view_t'(merged | views[i]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_kind    <= req_type;
      req_address <= hit_address;
      req_tid     <= thread_id;
      req_entry   <= entry_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total      <= '0;
      overflow_total <= '0;
    end else if (state == S_UPD) begin
      if (is_clear) begin
        hit_total      <= '0;
        overflow_total <= '0;
      end else if (is_hit) begin
        hit_total <= sat_inc(hit_total);
        if (!any_match && !any_free) begin
          overflow_total <= sat_inc(overflow_total);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      case (req_kind)
        REQ_HIT: begin
          if (any_match) begin
            status <= ST_EXISTING;
          end else if (any_free) begin
            status <= ST_CLAIMED;
          end else begin
            status <= ST_OVERFLOW;
          end
        end
        REQ_CLEAR: begin
          status <= ST_CLEARED;
        end
        default: begin
          status <= ST_READ;
        end
      endcase
      slot_index    <= is_read ? req_entry : merged.index;
      site_address  <= merged.address;
      site_count    <= merged.count;
      first_thread  <= merged.threads[0];
      second_thread <= merged.threads[1];
      third_thread  <= merged.threads[2];
      fourth_thread <= merged.threads[3];
      fifth_thread  <= merged.threads[4];
      sixth_thread  <= merged.threads[5];
      total_hits    <= hit_total;
      overflow_hits <= overflow_total;
    end
  end

endmodule

@@ tb/sv/tb_access_site_hit_table.sv @@
// self-checking testbench for the access site hit table: directed and random requests
module tb_access_site_hit_table;
  timeunit 1ns;
  timeprecision 1ps;

  import asht_pkg::*;

  localparam int unsigned ENTRIES    = 96;
  localparam int unsigned THREADS    = 6;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_TAIL = 12;

  typedef struct packed {
    logic [STATUS_W-1:0]            status;
    logic [SLOT_W-1:0]              slot;
    logic [ADDR_W-1:0]              address;
    logic [COUNT_W-1:0]             count;
    logic [THREADS-1:0][TID_W-1:0]  threads;
    logic [COUNT_W-1:0]             total;
    logic [COUNT_W-1:0]             overflow;
  } site_report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    req_type = REQ_READ;
  logic [ADDR_W-1:0]   hit_address = '0;
  logic [TID_W-1:0]    thread_id = '0;
  logic [SLOT_W-1:0]   entry_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [ADDR_W-1:0]   site_address;
  logic [COUNT_W-1:0]  site_count;
  logic [TID_W-1:0]    first_thread;
  logic [TID_W-1:0]    second_thread;
  logic [TID_W-1:0]    third_thread;
  logic [TID_W-1:0]    fourth_thread;
  logic [TID_W-1:0]    fifth_thread;
  logic [TID_W-1:0]    sixth_thread;
  logic [COUNT_W-1:0]  total_hits;
  logic [COUNT_W-1:0]  overflow_hits;

  // shadow of the table
  logic [ADDR_W-1:0]  site_addr [ENTRIES];
  logic [COUNT_W-1:0] site_cnt [ENTRIES];
  logic [TID_W-1:0]   site_thr [ENTRIES][THREADS];
  logic [COUNT_W-1:0] hit_sum;
  logic [COUNT_W-1:0] overflow_sum;

  site_report_t awaited_reports [$];
  site_report_t head_report;
  logic [ADDR_W-1:0] site_pool [40];
  logic [TID_W-1:0]  tid_pool [10];
  int unsigned mismatches = 0;
  int unsigned transfers_in = 0;
  int unsigned transfers_out = 0;
  int unsigned status_seen [5];
  int unsigned quiet_cycles = 0;
  bit steady = 1'b0;

  access_site_hit_table #(
    .ENTRIES          (ENTRIES),
    .THREADS_PER_ENTRY(THREADS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .hit_address  (hit_address),
    .thread_id    (thread_id),
    .entry_index  (entry_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot_index   (slot_index),
    .site_address (site_address),
    .site_count   (site_count),
    .first_thread (first_thread),
    .second_thread(second_thread),
    .third_thread (third_thread),
    .fourth_thread(fourth_thread),
    .fifth_thread (fifth_thread),
    .sixth_thread (sixth_thread),
    .total_hits   (total_hits),
    .overflow_hits(overflow_hits)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void wipe_table();
    for (int e = 0; e < ENTRIES; e++) begin
      site_addr[e] = '0;
      site_cnt[e] = '0;
      for (int k = 0; k < THREADS; k++) site_thr[e][k] = '0;
    end
    hit_sum = '0;
    overflow_sum = '0;
  endfunction

  function automatic void fill_entry(ref site_report_t r, input int e);
    r.address = site_addr[e];
    r.count = site_cnt[e];
    for (int k = 0; k < THREADS; k++) r.threads[k] = site_thr[e][k];
  endfunction

  function automatic site_report_t predict_table_access(logic [REQ_W-1:0] rt,
      logic [ADDR_W-1:0] addr, logic [TID_W-1:0] tid, logic [SLOT_W-1:0] idx);
    site_report_t r;
    int match;
    int free_slot;
    int e;
    bit placed;
    r = '0;
    match = -1;
    free_slot = -1;
    if (rt == REQ_HIT) begin
      hit_sum = bump(hit_sum);
      if (addr != '0) begin
        for (int i = 0; i < ENTRIES && match < 0; i++) begin
          if (site_addr[i] == addr) match = i;
          else if (site_addr[i] == '0 && free_slot < 0) free_slot = i;
        end
      end
      if (match < 0 && free_slot < 0) begin
        overflow_sum = bump(overflow_sum);
        r.status = ST_OVERFLOW;
      end else begin
        if (match >= 0) begin
          e = match;
          site_cnt[e] = bump(site_cnt[e]);
          r.status = ST_EXISTING;
        end else begin
          e = free_slot;
          site_addr[e] = addr;
          site_cnt[e] = COUNT_W'(1);
          r.status = ST_CLAIMED;
        end
        placed = (tid == '0);
        for (int k = 0; k < THREADS && !placed; k++) begin
          if (site_thr[e][k] == tid) placed = 1'b1;
          else if (site_thr[e][k] == '0) begin
            site_thr[e][k] = tid;
            placed = 1'b1;
          end
        end
        r.slot = SLOT_W'(e);
        fill_entry(r, e);
      end
    end else if (rt == REQ_CLEAR) begin
      wipe_table();
      r.status = ST_CLEARED;
    end else begin
      r.status = ST_READ;
      r.slot = idx;
      if (idx < ENTRIES) fill_entry(r, int'(idx));
    end
    r.total = hit_sum;
    r.overflow = overflow_sum;
    return r;
  endfunction

  task automatic send_req(logic [REQ_W-1:0] rt, logic [ADDR_W-1:0] addr,
      logic [TID_W-1:0] tid, logic [SLOT_W-1:0] idx);
    while (!steady && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    hit_address <= addr;
    thread_id <= tid;
    entry_index <= idx;
    do @(posedge clk); while (in_stall);
    transfers_in++;
    awaited_reports.push_back(predict_table_access(rt, addr, tid, idx));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_req(REQ_READ, rand64(), $urandom, 7'd0);
    send_req(REQ_READ, rand64(), $urandom, 7'd127);
    send_req(REQ_READ, rand64(), $urandom, 7'd96);
    send_req(REQ_READ, rand64(), $urandom, 7'd95);
    send_req(REQ_SPARE, rand64(), $urandom, 7'd5);
    // zero address always overflows
    send_req(REQ_HIT, '0, 32'd7, 7'd0);
    send_req(REQ_HIT, '1, '1, 7'd0);
    // zero thread is counted but not recorded
    send_req(REQ_HIT, '1, '0, 7'd0);
    for (int t = 2; t <= 6; t++) send_req(REQ_HIT, '1, TID_W'(t), 7'd0);
    // thread list full, new id dropped
    send_req(REQ_HIT, '1, 32'h8000_0001, 7'd0);
    send_req(REQ_HIT, '1, '1, 7'd0);
    send_req(REQ_READ, '0, '0, 7'd0);
    send_req(REQ_HIT, 64'h1, 32'h1, 7'd0);
    send_req(REQ_HIT, 64'h8000_0000_0000_0000, 32'h8000_0000, 7'd0);
    send_req(REQ_CLEAR, rand64(), $urandom, 7'd1);
    send_req(REQ_READ, '0, '0, 7'd0);
    send_req(REQ_HIT, 64'h1, 32'h1, 7'd0);
    send_req(REQ_READ, '0, '0, 7'd1);
  endtask

  task automatic test_repeat_sites();
    int pick;
    foreach (site_pool[i]) site_pool[i] = rand64();
    foreach (tid_pool[i]) tid_pool[i] = $urandom;
    steady = 1'b1;
    for (int n = 0; n < 420; n++) begin
      if (n == 150) steady = 1'b0;
      pick = $urandom_range(99);
      if (pick < 7) begin
        send_req(REQ_READ, rand64(), $urandom,
                 (pick < 4) ? SLOT_W'($urandom_range(45)) : SLOT_W'($urandom_range(127)));
      end else if (pick < 10) begin
        send_req(REQ_HIT, '0, tid_pool[$urandom_range(9)], SLOT_W'($urandom));
      end else if (pick < 15) begin
        send_req(REQ_HIT, site_pool[$urandom_range(39)], '0, SLOT_W'($urandom));
      end else begin
        send_req(REQ_HIT, site_pool[$urandom_range(39)], tid_pool[$urandom_range(9)],
                 SLOT_W'($urandom));
      end
    end
  endtask

  task automatic test_fill_and_overflow();
    int pick;
    drain_results();
    for (int n = 0; n < 180; n++) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_req(REQ_HIT, rand64(), $urandom, SLOT_W'($urandom));
      end else if (pick < 90) begin
        send_req(REQ_HIT, site_pool[$urandom_range(39)], tid_pool[$urandom_range(9)],
                 SLOT_W'($urandom));
      end else begin
        send_req(REQ_READ, rand64(), $urandom, SLOT_W'($urandom_range(127)));
      end
    end
  endtask

  task automatic test_clear_mix();
    int pick;
    for (int n = 0; n < 180; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_req(REQ_CLEAR, rand64(), $urandom, SLOT_W'($urandom));
      end else if (pick < 12) begin
        send_req(REQ_READ, rand64(), $urandom, SLOT_W'($urandom_range(127)));
      end else if (pick < 16) begin
        send_req(REQ_SPARE, rand64(), $urandom, SLOT_W'($urandom_range(20)));
      end else if (pick < 18) begin
        send_req(REQ_HIT, '0, $urandom, SLOT_W'($urandom));
      end else if (pick < 23) begin
        send_req(REQ_HIT, site_pool[$urandom_range(15)], '0, SLOT_W'($urandom));
      end else begin
        send_req(REQ_HIT, site_pool[$urandom_range(15)], tid_pool[$urandom_range(7)],
                 SLOT_W'($urandom));
      end
    end
  endtask

  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      transfers_out++;
      if (status < 5) status_seen[status]++;
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected result transfer, status %0d", $time, status);
        mismatches++;
      end else begin
        head_report = awaited_reports.pop_front();
        compare_field("status", 64'(head_report.status), 64'(status));
        compare_field("slot_index", 64'(head_report.slot), 64'(slot_index));
        compare_field("site_address", head_report.address, site_address);
        compare_field("site_count", head_report.count, site_count);
        compare_field("first_thread", 64'(head_report.threads[0]), 64'(first_thread));
        compare_field("second_thread", 64'(head_report.threads[1]), 64'(second_thread));
        compare_field("third_thread", 64'(head_report.threads[2]), 64'(third_thread));
        compare_field("fourth_thread", 64'(head_report.threads[3]), 64'(fourth_thread));
        compare_field("fifth_thread", 64'(head_report.threads[4]), 64'(fifth_thread));
        compare_field("sixth_thread", 64'(head_report.threads[5]), 64'(sixth_thread));
        compare_field("total_hits", head_report.total, total_hits);
        compare_field("overflow_hits", head_report.overflow, overflow_hits);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, awaited_reports.size());
        $display("tb_access_site_hit_table: FAIL");
        $finish;
      end
    end
  end

  initial begin
    wipe_table();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_repeat_sites();
    test_fill_and_overflow();
    test_clear_mix();
    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("requests %0d, results %0d: counted %0d, claimed %0d, overflow %0d",
             transfers_in, transfers_out, status_seen[0], status_seen[1], status_seen[2]);
    $display("reads %0d, clears %0d, mismatches %0d", status_seen[3], status_seen[4],
             mismatches);
    if (mismatches == 0) begin
      $display("tb_access_site_hit_table: PASS");
    end else begin
      $display("tb_access_site_hit_table: FAIL");
    end
    $finish;
  end

endmodule

@@ access_site_hit_table.f @@
design/asht_pkg.sv
design/asht_cell.sv
design/access_site_hit_table.sv
tb/sv/tb_access_site_hit_table.sv
